// ===== sv/mfu_pkg.sv =====
package mfu_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 5;

  localparam logic [BYTE_W-1:0] MARK_START = 8'd254;
  localparam logic [BYTE_W-1:0] MARK_END   = 8'd255;
  localparam logic [BYTE_W-1:0] MARK_ESC   = 8'd253;

  typedef struct packed {
    logic accept;
    logic start_drain;
    logic fetch;
    logic advance;
  } mfu_cmd_t;

  typedef struct packed {
    logic emit;
    logic last_item;
  } mfu_status_t;

endpackage

// ===== sv/marker_frame_unstuffer.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte
// output    out_valid / out_stall  msg_type, byte_index, payload_byte, last
//
// Each received byte is accepted while in_valid is high and no frame is being drained.
// A completed frame is drained beat by beat: each beat first reads the
// payload memory, then presents the registered result.
// The input is stalled for the whole drain, from the end marker to the last beat.
// Reset is synchronous and clears the framing state; the payload memory needs no clearing.
// A stalled output beat holds its value until it is taken.
module marker_frame_unstuffer
  import mfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] msg_type,
  output logic [IDX_W-1:0]  byte_index,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              last
);

  mfu_cmd_t    cmd;
  mfu_status_t status;

  mfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mfu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .msg_type     (msg_type),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .last         (last)
  );

endmodule

// ===== sv/mfu_ctrl.sv =====
module mfu_ctrl
  import mfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  mfu_status_t status,
  output mfu_cmd_t    cmd
);

  typedef enum logic [1:0] {
    RECV,
    FETCH,
    SHOW
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept      = (state == RECV) && in_valid;
    cmd.start_drain = (state == RECV) && in_valid && status.emit;
    cmd.fetch       = (state == FETCH);
    cmd.advance     = (state == SHOW) && !out_stall && !status.last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RECV;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        RECV: begin
          if (in_valid && status.emit) begin
            state    <= FETCH;
            in_stall <= 1'b1;
          end
        end
        FETCH: begin
          state     <= SHOW;
          out_valid <= 1'b1;
        end
        SHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (status.last_item) begin
              state    <= RECV;
              in_stall <= 1'b0;
            end else begin
              state <= FETCH;
            end
          end
        end
        default: begin
          state     <= RECV;
          in_stall  <= 1'b0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/mfu_dp.sv =====
module mfu_dp
  import mfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] rx_byte,
  input  mfu_cmd_t          cmd,
  output mfu_status_t       status,
  output logic [BYTE_W-1:0] msg_type,
  output logic [IDX_W-1:0]  byte_index,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              last
);

  logic               in_frame;
  logic               type_seen;
  logic [BYTE_W-1:0]  frame_type;
  logic               escape_pending;
  logic               overflowed;
  logic [COUNT_W-1:0] payload_count;

  logic [BYTE_W-1:0]  payload_store [MAX_PAYLOAD];

  logic [BYTE_W-1:0]  drain_type;
  logic [ADDR_W-1:0]  drain_last;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [BYTE_W-1:0]  rd_data;

  logic               store_en;
  logic [BYTE_W-1:0]  store_val;

  always_comb begin
    status.emit      = (rx_byte == MARK_END) && in_frame && type_seen && !overflowed
                       && (payload_count != '0);
    status.last_item = (rd_ptr == drain_last);
  end

  always_comb begin
    store_en  = 1'b0;
    store_val = rx_byte;
    if (cmd.accept && in_frame && type_seen && rx_byte != MARK_START && rx_byte != MARK_END)
    begin
      if (escape_pending) begin
        store_en  = 1'b1;
        store_val = BYTE_W'(MARK_ESC + rx_byte);
      end else if (rx_byte != MARK_ESC) begin
        store_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      type_seen      <= 1'b0;
      frame_type     <= '0;
      escape_pending <= 1'b0;
      overflowed     <= 1'b0;
      payload_count  <= '0;
    end else if (cmd.accept) begin
      if (rx_byte == MARK_START) begin
        in_frame       <= 1'b1;
        type_seen      <= 1'b0;
        frame_type     <= '0;
        escape_pending <= 1'b0;
        overflowed     <= 1'b0;
        payload_count  <= '0;
      end else if (in_frame) begin
        if (rx_byte == MARK_END) begin
          in_frame       <= 1'b0;
          type_seen      <= 1'b0;
          frame_type     <= '0;
          escape_pending <= 1'b0;
          overflowed     <= 1'b0;
          payload_count  <= '0;
        end else if (!type_seen) begin
          frame_type <= rx_byte;
          type_seen  <= 1'b1;
        end else if (escape_pending) begin
          escape_pending <= 1'b0;
        end else if (rx_byte == MARK_ESC) begin
          escape_pending <= 1'b1;
        end
        if (store_en) begin
          if (payload_count < COUNT_W'(MAX_PAYLOAD)) begin
            payload_count <= payload_count + COUNT_W'(1);
          end else begin
            overflowed <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en && payload_count < COUNT_W'(MAX_PAYLOAD)) begin
      payload_store[payload_count[ADDR_W-1:0]] <= store_val;
    end
    if (cmd.fetch) begin
      rd_data <= payload_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_drain) begin
      drain_type <= frame_type;
      drain_last <= ADDR_W'(payload_count - COUNT_W'(1));
      rd_ptr     <= '0;
    end else if (cmd.advance) begin
      rd_ptr <= rd_ptr + ADDR_W'(1);
    end
  end

  assign msg_type     = drain_type;
  assign byte_index   = IDX_W'(rd_ptr);
  assign payload_byte = rd_data;
  assign last         = (rd_ptr == drain_last);

endmodule
